// ----- design/fcb_pkg.sv -----
// fcb_pkg: types, frame constants and queue sizing for the pump command frame builder
// no dependencies; imported by every module of the block
`default_nettype none

package fcb_pkg;

    // frame marker and password bytes
    localparam logic [7:0] FRAME_HEAD = 8'hCC;
    localparam logic [7:0] FRAME_END  = 8'hDD;
    localparam logic [7:0] PASS_A     = 8'hFF;
    localparam logic [7:0] PASS_B     = 8'hEE;
    localparam logic [7:0] PASS_C     = 8'hBB;
    localparam logic [7:0] PASS_D     = 8'hAA;

    // frame lengths in bytes
    localparam logic [3:0] FACTORY_LEN = 4'd14;
    localparam logic [3:0] GENERAL_LEN = 4'd8;

    // checksum contribution of the fixed bytes of each frame class
    localparam logic [15:0] FACTORY_SUM_BASE = 16'(FRAME_HEAD) + 16'(PASS_A) + 16'(PASS_B)
                                             + 16'(PASS_C) + 16'(PASS_D) + 16'(FRAME_END);
    localparam logic [15:0] GENERAL_SUM_BASE = 16'(FRAME_HEAD) + 16'(FRAME_END);

    // configuration port
    localparam int          APB_ADDR_W         = 3;
    localparam logic        REG_DEVICE_ADDRESS = 1'b0;

    // descriptor queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef struct packed {
        logic [7:0]  command;
        logic [31:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_out_item;

    typedef enum logic {
        CLASS_GENERAL = 1'b0,
        CLASS_FACTORY = 1'b1
    } t_frame_class;

    typedef struct packed {
        t_frame_class frame_class;
        logic [7:0]   address;
        logic [7:0]   command;
        logic [31:0]  data_word;
        logic [15:0]  sum;
    } t_frame_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage : fcb_pkg

`default_nettype wire

// ----- design/fcb_front.sv -----
// fcb_front: accepts command items, classifies them and builds a frame descriptor with checksum
// depends on fcb_pkg
`default_nettype none

module fcb_front import fcb_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_in_item      i_item,
    input  wire logic [7:0]    i_device_address,
    input  wire t_queue_status i_q_status,
    output logic               o_full,
    output logic               o_q_write,
    output t_frame_desc        o_desc
);

    logic        r_valid, n_valid;
    t_frame_desc r_desc, n_desc;
    logic        accept;
    logic        factory_code, general_code;
    logic [7:0]  d0, d1, d2, d3;

    // factory command codes
    always_comb begin
        unique case (i_item.command)
            8'h00, 8'h01, 8'h02, 8'h03, 8'h07, 8'h0A, 8'h0B, 8'h0C,
            8'h0E, 8'h10, 8'hFF: factory_code = 1'b1;
            default:             factory_code = 1'b0;
        endcase
    end

    // general command codes
    always_comb begin
        unique case (i_item.command)
            8'h20, 8'h21, 8'h22, 8'h23, 8'h27, 8'h2A, 8'h2B, 8'h2C,
            8'h2D, 8'h30, 8'h3E, 8'h3F, 8'h42, 8'h44, 8'h45, 8'h49,
            8'h4A, 8'h4B, 8'h4D, 8'h65, 8'h66, 8'h67, 8'h68: general_code = 1'b1;
            default:                                          general_code = 1'b0;
        endcase
    end

    assign d0 = i_item.data_word[7:0];
    assign d1 = i_item.data_word[15:8];
    assign d2 = i_item.data_word[23:16];
    assign d3 = i_item.data_word[31:24];

    // stage holds one descriptor; stalls only when it is full and the queue is too
    assign o_full    = r_valid && i_q_status.full;
    assign o_q_write = r_valid && !i_q_status.full;
    assign accept    = i_push && !o_full;
    assign o_desc    = r_desc;

    // descriptor build and stage control
    always_comb begin
        n_valid = r_valid && !o_q_write;
        n_desc  = r_desc;
        if (accept && (factory_code || general_code)) begin
            n_valid             = 1'b1;
            n_desc.frame_class  = factory_code ? CLASS_FACTORY : CLASS_GENERAL;
            n_desc.address      = i_device_address;
            n_desc.command      = i_item.command;
            n_desc.data_word    = i_item.data_word;
            if (factory_code) begin
                n_desc.sum = FACTORY_SUM_BASE + 16'(i_device_address) + 16'(i_item.command)
                           + 16'(d0) + 16'(d1) + 16'(d2) + 16'(d3);
            end else begin
                n_desc.sum = GENERAL_SUM_BASE + 16'(i_device_address) + 16'(i_item.command)
                           + 16'(d0) + 16'(d1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
    end

    // a held descriptor is not dropped while the queue is full
    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_q_status.full) |=> r_valid)
        else $error("front descriptor lost while queue full");

endmodule : fcb_front

`default_nettype wire

// ----- design/fcb_queue.sv -----
// fcb_queue: short descriptor queue that decouples the front from the serialiser
// depends on fcb_pkg
`default_nettype none

module fcb_queue import fcb_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_write,
    input  wire t_frame_desc   i_desc,
    input  wire logic          i_read,
    output t_queue_status      o_status,
    output t_frame_desc        o_head
);

    t_frame_desc                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [QUEUE_PTR_W:0]       r_count, n_count;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(logic [QUEUE_PTR_W-1:0] p);
        logic [QUEUE_PTR_W-1:0] r;
        if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign o_status.full  = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = i_write ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_read  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_write && !i_read) begin
            n_count = r_count + 1'b1;
        end else if (i_read && !i_write) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_write) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

endmodule : fcb_queue

`default_nettype wire

// ----- design/fcb_back.sv -----
// fcb_back: serialises the head descriptor one frame byte per cycle unless the output stalls
// depends on fcb_pkg
`default_nettype none

module fcb_back import fcb_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_queue_status i_q_status,
    input  wire t_frame_desc   i_head,
    input  wire logic          i_pop,
    output logic               o_q_read,
    output logic               o_empty,
    output t_out_item          o_item
);

    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;
    logic [3:0] r_pos, n_pos;
    logic [3:0] frame_len;
    logic       out_free;
    logic       last_byte;

    function automatic logic [7:0] frame_byte(t_frame_desc d, logic [3:0] pos);
        logic [7:0] b;
        if (d.frame_class == CLASS_FACTORY) begin
            unique case (pos)
                4'd0:    b = FRAME_HEAD;
                4'd1:    b = d.address;
                4'd2:    b = d.command;
                4'd3:    b = PASS_A;
                4'd4:    b = PASS_B;
                4'd5:    b = PASS_C;
                4'd6:    b = PASS_D;
                4'd7:    b = d.data_word[7:0];
                4'd8:    b = d.data_word[15:8];
                4'd9:    b = d.data_word[23:16];
                4'd10:   b = d.data_word[31:24];
                4'd11:   b = FRAME_END;
                4'd12:   b = d.sum[7:0];
                4'd13:   b = d.sum[15:8];
                default: b = '0;
            endcase
        end else begin
            unique case (pos)
                4'd0:    b = FRAME_HEAD;
                4'd1:    b = d.address;
                4'd2:    b = d.command;
                4'd3:    b = d.data_word[7:0];
                4'd4:    b = d.data_word[15:8];
                4'd5:    b = FRAME_END;
                4'd6:    b = d.sum[7:0];
                4'd7:    b = d.sum[15:8];
                default: b = '0;
            endcase
        end
        return b;
    endfunction

    assign frame_len = (i_head.frame_class == CLASS_FACTORY) ? FACTORY_LEN : GENERAL_LEN;
    assign last_byte = (r_pos == frame_len - 4'd1);
    assign out_free  = !r_out_valid || i_pop;
    assign o_q_read  = out_free && !i_q_status.empty && last_byte;
    assign o_empty   = !r_out_valid;
    assign o_item    = r_out;

    // byte sequencing: load the output register whenever it is free and a descriptor is queued
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_pos       = r_pos;
        if (out_free) begin
            if (!i_q_status.empty) begin
                n_out_valid   = 1'b1;
                n_out.tx_byte = frame_byte(i_head, r_pos);
                n_out.last    = last_byte;
                n_pos         = last_byte ? 4'd0 : r_pos + 4'd1;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
        end
    end

    // output payload, no reset
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // position rests at zero between frames
    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_status.empty |-> (r_pos == 4'd0))
        else $error("byte position not zero with no frame pending");

    // position stays inside the current frame
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_status.empty |-> (r_pos < frame_len))
        else $error("byte position beyond frame length");

    // a descriptor leaves the queue exactly when its last byte is loaded
    a_read_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_read |=> (r_out_valid && r_out.last))
        else $error("descriptor retired without last byte");

endmodule : fcb_back

`default_nettype wire

// ----- design/pump_command_frame_builder.sv -----
// pump_command_frame_builder: top level, configuration register and front/queue/back wiring
// depends on fcb_pkg, fcb_front, fcb_queue, fcb_back
//
// usage
//   input side is a queue: present i_item and raise push; the item is taken at a clock
//   edge where push is high and full is low. known command codes become frames, other
//   codes are taken and dropped with no output.
//   output side is a queue: while empty is low, o_item holds the oldest frame byte with
//   last set on the final byte; raising pop takes it.
//   device_address is written over the apb port at byte address 0; write only while idle.
// timing
//   the first byte passes through the front stage, the descriptor queue and the output
//   register; then one byte per cycle while pop stays high. a factory frame is 14 bytes, a general one 8.
//   the serialiser's one-byte-per-cycle output register sets this rate; frames follow
//   each other with no gap.
//   a two-entry descriptor queue plus the front stage hold up to three items, so the
//   next commands are taken while a frame is still being sent.
// reset and stall
//   synchronous active-low reset empties all stages and clears device_address.
//   when pop is low the output byte holds; the queue fills and then full rises.
`default_nettype none

module pump_command_frame_builder import fcb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command items in
    input  wire logic                  push,
    output logic                       full,
    input  wire t_in_item              i_item,
    // frame bytes out
    output logic                       empty,
    input  wire logic                  pop,
    output t_out_item                  o_item,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [7:0]    r_device_address;
    logic          cfg_write;
    logic          q_write;
    logic          q_read;
    t_frame_desc   front_desc;
    t_frame_desc   q_head;
    t_queue_status q_status;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1:2] == REG_DEVICE_ADDRESS);
    assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_DEVICE_ADDRESS)
                     ? {24'h000000, r_device_address} : 32'h0000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= '0;
        end else if (cfg_write) begin
            r_device_address <= pwdata[7:0];
        end
    end

    // front: accept and classify
    fcb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_item           (i_item),
        .i_device_address (r_device_address),
        .i_q_status       (q_status),
        .o_full           (full),
        .o_q_write        (q_write),
        .o_desc           (front_desc)
    );

    // descriptor queue
    fcb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_write  (q_write),
        .i_desc   (front_desc),
        .i_read   (q_read),
        .o_status (q_status),
        .o_head   (q_head)
    );

    // back: byte serialiser
    fcb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (q_head),
        .i_pop      (pop),
        .o_q_read   (q_read),
        .o_empty    (empty),
        .o_item     (o_item)
    );

endmodule : pump_command_frame_builder

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench: command items into pump_command_frame_builder, every frame byte checked in order
// depends on fcb_pkg and the pump_command_frame_builder rtl

module testbench;
    import fcb_pkg::*;

    // command code lists, in listed order through the code helpers
    localparam int N_FACTORY = 11;
    localparam int N_GENERAL = 23;
    localparam int N_UNKNOWN = 6;
    localparam logic [N_FACTORY*8-1:0] FACTORY_CODES = {
        8'h00, 8'h01, 8'h02, 8'h03, 8'h07, 8'h0A, 8'h0B, 8'h0C, 8'h0E, 8'h10, 8'hFF};
    localparam logic [N_GENERAL*8-1:0] GENERAL_CODES = {
        8'h20, 8'h21, 8'h22, 8'h23, 8'h27, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h30, 8'h3E, 8'h3F,
        8'h42, 8'h44, 8'h45, 8'h49, 8'h4A, 8'h4B, 8'h4D, 8'h65, 8'h66, 8'h67, 8'h68};
    // unknown codes, most lying next to the edges of the known ranges
    localparam logic [N_UNKNOWN*8-1:0] UNKNOWN_CODES = {
        8'h04, 8'h11, 8'h1F, 8'h69, 8'h80, 8'hFE};

    localparam logic [APB_ADDR_W-1:0] ADDR_DEVICE   = APB_ADDR_W'(0);
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = APB_ADDR_W'(4);

    localparam int FLUSH_CYCLES   = 16;
    localparam int PHASES         = 4;
    localparam int PHASE_ITEMS    = 40;
    localparam int HOLD_OFF       = 80;
    localparam int MAX_WAIT       = 10;
    localparam int REPORT_LIMIT   = 10;

    typedef enum {KIND_NONE, KIND_GENERAL, KIND_FACTORY} t_frame_kind;

    function automatic logic [7:0] factory_code(int idx);
        return FACTORY_CODES[(N_FACTORY-1-idx)*8 +: 8];
    endfunction

    function automatic logic [7:0] general_code(int idx);
        return GENERAL_CODES[(N_GENERAL-1-idx)*8 +: 8];
    endfunction

    function automatic logic [7:0] unknown_code(int idx);
        return UNKNOWN_CODES[(N_UNKNOWN-1-idx)*8 +: 8];
    endfunction

    function automatic t_frame_kind classify(logic [7:0] code);
        for (int i = 0; i < N_FACTORY; i++)
            if (factory_code(i) == code) return KIND_FACTORY;
        for (int i = 0; i < N_GENERAL; i++)
            if (general_code(i) == code) return KIND_GENERAL;
        return KIND_NONE;
    endfunction

    // frame predictor and byte checker
    class frame_scoreboard;
        logic [7:0] address;
        t_out_item  expected_bytes[$];
        int         fail_count;

        function new();
            address    = '0;
            fail_count = 0;
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        endfunction

        // build the frame a command gives and queue its bytes
        function void note_command(t_in_item item);
            logic [7:0]  frame[$];
            logic [15:0] sum;
            t_frame_kind kind;
            t_out_item   b;
            kind = classify(item.command);
            if (kind == KIND_NONE) return;
            frame.push_back(FRAME_HEAD);
            frame.push_back(address);
            frame.push_back(item.command);
            if (kind == KIND_FACTORY) begin
                frame.push_back(PASS_A);
                frame.push_back(PASS_B);
                frame.push_back(PASS_C);
                frame.push_back(PASS_D);
                frame.push_back(item.data_word[7:0]);
                frame.push_back(item.data_word[15:8]);
                frame.push_back(item.data_word[23:16]);
                frame.push_back(item.data_word[31:24]);
            end else begin
                frame.push_back(item.data_word[7:0]);
                frame.push_back(item.data_word[15:8]);
            end
            frame.push_back(FRAME_END);
            sum = '0;
            foreach (frame[i]) sum += 16'(frame[i]);
            frame.push_back(sum[7:0]);
            frame.push_back(sum[15:8]);
            foreach (frame[i]) begin
                b.tx_byte = frame[i];
                b.last    = (i == frame.size() - 1);
                expected_bytes.push_back(b);
            end
        endfunction

        function void check_byte(t_out_item got);
            t_out_item want;
            if (expected_bytes.size() == 0) begin
                report("byte with none expected", '0, 32'(got));
                return;
            end
            want = expected_bytes.pop_front();
            if (got.tx_byte !== want.tx_byte)
                report("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
            if (got.last !== want.last) report("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    t_in_item              i_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_out_item             o_item;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    frame_scoreboard sb;
    int send_max = MAX_WAIT;
    int hold_cycles = 0;
    int code_cursor = 0;

    pump_command_frame_builder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // offer one command after a random gap, hold it until taken
    task automatic send_command(logic [7:0] cmd, logic [31:0] data);
        int gap;
        gap = $urandom_range(0, send_max);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push = 1'b1;
        i_item.command   = cmd;
        i_item.data_word = data;
        do @(posedge i_clk); while (full);
        sb.note_command(i_item);
        @(negedge i_clk);
    endtask

    task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_DEVICE) sb.address = data[7:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_address_readback();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_DEVICE;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(sb.address)) sb.report("device_address readback",
                                                  32'(sb.address), prdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // stop offering until every expected byte is out, then let unknown items clear
    task automatic wait_idle();
        push = 1'b0;
        while (sb.expected_bytes.size() != 0) @(negedge i_clk);
        repeat (FLUSH_CYCLES) @(negedge i_clk);
    endtask

    // mostly known codes in turn, the rest any byte at all
    task automatic send_random_command();
        logic [7:0]  cmd;
        logic [31:0] data;
        if ($urandom_range(0, 99) < 85) begin
            if (code_cursor < N_FACTORY) cmd = factory_code(code_cursor);
            else cmd = general_code(code_cursor - N_FACTORY);
            code_cursor = (code_cursor + 1) % (N_FACTORY + N_GENERAL);
        end else begin
            cmd = 8'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 7))
            0:       data = '0;
            1:       data = '1;
            default: data = $urandom;
        endcase
        send_command(cmd, data);
    endtask

    // result side: random stalls, long hold-off on request
    initial begin : result_side
        int stall;
        int pop_max;
        int taken;
        pop_max = MAX_WAIT;
        taken   = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                pop = 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end
            if (taken % 40 == 0) pop_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
            stall = $urandom_range(0, pop_max);
            if (stall > 0) begin
                pop = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_byte(o_item);
            taken++;
            @(negedge i_clk);
        end
    end

    // command side and configuration
    initial begin : command_side
        logic [7:0] next_address;
        sb = new();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: class edges, data extremes, unknown codes between frames
        check_address_readback();
        send_command(factory_code(0), 32'h0000_0000);
        send_command(factory_code(N_FACTORY-1), 32'hFFFF_FFFF);
        send_command(general_code(0), 32'h0000_0000);
        send_command(general_code(N_GENERAL-1), 32'hFFFF_FFFF);
        send_command(unknown_code(0), 32'h1234_5678);
        send_command(general_code(11), 32'hFFFF_0000);
        send_command(factory_code(9), 32'hA5A5_5A5A);
        send_command(unknown_code(4), 32'h0000_0000);
        send_command(unknown_code(5), 32'hFFFF_FFFF);
        send_command(general_code(5), 32'h0000_FFFF);
        send_command(factory_code(8), 32'h0000_0001);
        send_command(unknown_code(1), 32'h8000_0000);
        send_command(unknown_code(2), 32'h0000_0001);
        send_command(unknown_code(3), 32'h5555_AAAA);
        send_command(factory_code(4), 32'h8000_0000);
        send_command(general_code(18), 32'h0000_8001);

        // random phases, each under its own device address
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0:       next_address = 8'hFF;
                1:       next_address = 8'h00;
                default: next_address = 8'($urandom_range(1, 254));
            endcase
            reg_write(ADDR_DEVICE, {8'($urandom_range(0, 255)), 24'h0} | 32'(next_address));
            if (ph == 0) reg_write(ADDR_UNMAPPED, $urandom);
            check_address_readback();

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 10 == 0) send_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
                // receiver holds off while commands arrive back to back
                if (ph == 1 && k == 0) hold_cycles = HOLD_OFF;
                if (ph == 1 && k < 12) send_max = 0;
                // full drain in the middle of a phase
                if (ph == 2 && k == 20) wait_idle();
                send_random_command();
            end
        end

        wait_idle();
        if (sb.fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
